// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk outside reset.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check a consequent in the cycle after an antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // Default configuration
    localparam int CAPACITY_DEFAULT = 64;
    localparam int KEY_BITS_DEFAULT = 16;

    // Width of the key fields on the ports
    localparam int KEY_IO_BITS = 16;

    // Operation codes on func
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_REMOVED   = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== design/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Min-priority queue kept as a sorted row of CAPACITY cells. Each beat on the
// input either inserts key_in (func = insert) or removes the smallest key
// (func = remove); every input beat yields exactly one output beat carrying
// key_out, status and the occupancy after the operation. Equal keys leave in
// arrival order. Remove on an empty queue reports underflow, insert on a
// full queue drops the key and reports overflow; both leave the contents
// unchanged, and key_out is zero for anything but a successful remove. All
// cells compare against the incoming key in parallel and shift by one slot
// in the same cycle: the block takes an input beat every cycle as long as
// the output register is empty or is being drained, and the result appears
// in the cycle after the input beat. Rate is set by the compare-and-shift
// of the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT,
    parameter int KEY_BITS = KEY_BITS_DEFAULT
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              func,
    input  wire logic [KEY_IO_BITS-1:0]            key_in,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [KEY_IO_BITS-1:0]                 key_out,
    output logic [1:0]                             status,
    output logic [$clog2(CAPACITY+1)-1:0]          occupancy
);

    `include "assert_macros.svh"

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    // Fill count and output register
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [KEY_IO_BITS-1:0] key_out_reg;
    logic [KEY_IO_BITS-1:0] key_out_next;
    logic [1:0]             status_reg;
    logic [1:0]             status_next;
    logic [CNT_BITS-1:0]    occ_reg;
    logic [CNT_BITS-1:0]    occ_next;

    logic                   accept;
    logic                   full;
    logic                   empty;
    cell_cmd_t              cmd;
    logic [KEY_BITS-1:0]    new_key;
    logic [KEY_IO_BITS-1:0] head_key_io;

    // Cell chain: take_w[i] / key_w[i] come from cell i; the last cell has
    // no right neighbor and takes its own key back on remove.
    logic                   take_w [0:CAPACITY-1];
    logic [KEY_BITS-1:0]    key_w  [0:CAPACITY-1];

    // Accept a new beat whenever the output register is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign full  = (count_reg == CNT_BITS'(CAPACITY));
    assign empty = (count_reg == '0);

    // Commands for the cell row; refused operations touch nothing
    assign cmd.ins = accept && (func == OP_INSERT) && !full;
    assign cmd.rem = accept && (func == OP_REMOVE) && !empty;

    // Fit the port key into the stored key width and back
    generate
        if (KEY_BITS <= KEY_IO_BITS)
        begin : g_key_narrow
            assign new_key = key_in[KEY_BITS-1:0];
            assign head_key_io = KEY_IO_BITS'(key_w[0]);
        end
        else
        begin : g_key_wide
            assign new_key = KEY_BITS'(key_in);
            assign head_key_io = key_w[0][KEY_IO_BITS-1:0];
        end
    endgenerate

    // Row of cells: each takes from its left on insert, from its right on
    // remove. Cell zero always holds the smallest key.
    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                left_take;
            logic [KEY_BITS-1:0] left_key;
            logic [KEY_BITS-1:0] right_key;

            if (i == 0)
            begin : g_first
                assign left_take = 1'b0;
                assign left_key  = new_key;
            end
            else
            begin : g_mid
                assign left_take = take_w[i-1];
                assign left_key  = key_w[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_key = key_w[i];
            end
            else
            begin : g_inner
                assign right_key = key_w[i+1];
            end

            spq_cell #(
                .KEY_BITS (KEY_BITS),
                .CNT_BITS (CNT_BITS),
                .IDX      (i)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .count     (count_reg),
                .new_key   (new_key),
                .left_take (left_take),
                .left_key  (left_key),
                .right_key (right_key),
                .take      (take_w[i]),
                .key       (key_w[i])
            );
        end
    endgenerate

    // Next count and result beat
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        key_out_next   = key_out_reg;
        status_next    = status_reg;
        occ_next       = occ_reg;

        if (cmd.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - 1'b1;
        end

        // Drop the held beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            key_out_next   = '0;
            occ_next       = count_next;
            if (func == OP_INSERT)
            begin
                status_next = full ? ST_OVERFLOW : ST_INSERTED;
            end
            else if (empty)
            begin
                status_next = ST_UNDERFLOW;
            end
            else
            begin
                status_next  = ST_REMOVED;
                key_out_next = head_key_io;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload holds until the next accepted beat
    always_ff @(posedge clk)
    begin
        key_out_reg <= key_out_next;
        status_reg  <= status_next;
        occ_reg     <= occ_next;
    end

    assign out_valid = out_valid_reg;
    assign key_out   = key_out_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

    `SPQ_ASSERT(a_count_bound, count_reg <= CNT_BITS'(CAPACITY), "fill count exceeds capacity")
    `SPQ_ASSERT_NEXT(a_remove_count, cmd.rem, count_reg == $past(count_reg) - 1'b1, "remove did not drop count")
    `SPQ_ASSERT(a_overflow_full, !(out_valid_reg && status_reg == ST_OVERFLOW) || occ_reg == CNT_BITS'(CAPACITY), "overflow reported below capacity")
    `SPQ_ASSERT(a_head_sorted, count_reg < CNT_BITS'(2) || key_w[0] <= key_w[1], "head cells out of order")

endmodule

`default_nettype wire

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a key, compares it with the incoming key
// and takes its left or right neighbor's key on insert or remove.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEFAULT,
    parameter int CNT_BITS = 7,
    parameter int IDX      = 0
)
(
    input  wire logic                clk,
    input  wire cell_cmd_t           cmd,
    input  wire logic [CNT_BITS-1:0] count,
    input  wire logic [KEY_BITS-1:0] new_key,
    input  wire logic                left_take,
    input  wire logic [KEY_BITS-1:0] left_key,
    input  wire logic [KEY_BITS-1:0] right_key,
    output logic                     take,
    output logic [KEY_BITS-1:0]      key
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                occupied;

    // Slot is live when it lies below the fill count
    assign occupied = (CNT_BITS'(IDX) < count);

    // New key lands here or further left: slot empty or holds a larger key
    assign take = !occupied || (key_reg > new_key);

    always_comb
    begin
        key_next = key_reg;
        if (cmd.ins && take)
        begin
            key_next = left_take ? left_key : new_key;
        end
        else if (cmd.rem)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

`default_nettype wire
